// ===== hw/rtl/msd_pkg.sv =====
package msd_pkg;

    localparam int SAMPLE_W  = 16;  // input sample, two's complement
    localparam int OUT_W     = 24;  // mean and std result fields
    localparam int COUNT_W   = 7;   // sample count result field
    localparam int MEAN_FRAC = 8;   // Q8 mean
    localparam int VAR_FRAC  = 16;  // Q16 variance feeds the root
    localparam int VAR_W     = 46;  // Q16 variance of 16-bit data stays below 2^46
    localparam int ROOT_W    = VAR_W / 2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       is_last;
    } t_msd_in;

    typedef struct packed {
        logic signed [OUT_W-1:0]   mean_q8;
        logic        [OUT_W-1:0]   std_q8;
        logic        [COUNT_W-1:0] sample_count;
    } t_msd_out;

endpackage

// ===== hw/rtl/msd_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle.
module msd_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [AW-1:0]  i_a,
    input  logic [BW-1:0]  i_b,
    output logic           o_done,
    output logic [AW+BW-1:0] o_prod
);
    localparam int CNT_W = $clog2(BW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [AW-1:0]    r_a;
    logic [AW+BW-1:0] r_p;
    logic [AW:0]      n_hi;
    logic [AW+BW-1:0] n_p;

    assign n_hi = {1'b0, r_p[AW+BW-1:BW]} + (r_p[0] ? {1'b0, r_a} : {(AW+1){1'b0}});
    assign n_p  = {n_hi, r_p[BW-1:1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(BW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_p <= {{AW{1'b0}}, i_b};
        end else if (r_busy) begin
            r_p <= n_p;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_p;

endmodule

// ===== hw/rtl/msd_div.sv =====
// Restoring divider, one dividend bit per cycle, MSB first.
module msd_div #(
    parameter int NW = 60,
    parameter int DW = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quot,
    output logic [DW-1:0] o_rem
);
    localparam int CNT_W = $clog2(NW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_q;
    logic [DW-1:0]    r_r;
    logic [DW-1:0]    r_d;
    logic [DW:0]      trial;
    logic [DW+1:0]    diff;
    logic             ge;

    assign trial = {r_r, r_q[NW-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_d};
    assign ge    = !diff[DW+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= i_dividend;
            r_r <= '0;
            r_d <= i_divisor;
        end else if (r_busy) begin
            r_q <= {r_q[NW-2:0], ge};
            r_r <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r;

endmodule

// ===== hw/rtl/msd_sqrt.sv =====
// Digit-by-digit integer square root, two radicand bits per cycle.
module msd_sqrt #(
    parameter int RW = 46
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RW-1:0]   i_rad,
    output logic            o_done,
    output logic [RW/2-1:0] o_root
);
    localparam int HW    = RW / 2;
    localparam int CNT_W = $clog2(HW);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [RW-1:0]    r_x;
    logic [HW-1:0]    r_root;
    logic [HW:0]      r_rem;
    logic [HW+2:0]    t;
    logic [HW+2:0]    trial;
    logic [HW+3:0]    diff;
    logic             ge;

    assign t     = {r_rem, r_x[RW-1:RW-2]};
    assign trial = {1'b0, r_root, 2'b01};
    assign diff  = {1'b0, t} - {1'b0, trial};
    assign ge    = !diff[HW+3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(HW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_rad;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[RW-3:0], 2'b00};
            r_root <= {r_root[HW-2:0], ge};
            r_rem  <= ge ? diff[HW:0] : t[HW:0];
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ===== hw/rtl/mean_and_std_deviation.sv =====
// Channel   Direction  Valid        Stall        Word
// input     in         i_in_valid   o_in_stall   i_in_word  (sample, is_last)
// result    out        o_out_valid  i_out_stall  o_out_word (mean_q8, std_q8, sample_count)
//
// Each accepted sample is taken in, squared in the serial squarer and then added into
// the running sums; o_in_stall holds the next sample until then. A sample that
// arrives with the set full is dropped in its accept cycle. The word with is_last
// starts the closing pass: three serial multiplies, two serial divides and the
// serial root.
// Reset is synchronous and clears the sums and the handshake state.
// The result sits in an output register; a stalled result only holds the closing
// pass in its last state, while samples of the next set wait on o_in_stall.
module mean_and_std_deviation #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  msd_pkg::t_msd_in  i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output msd_pkg::t_msd_out o_out_word
);
    import msd_pkg::*;

    // accumulator widths follow the set size
    localparam int CW  = $clog2(MAX_SAMPLES + 1);    // sample tally
    localparam int MW  = SAMPLE_W - 1 + CW;          // |sum|
    localparam int SW  = MW + 1;                     // signed sum
    localparam int QW  = 2 * SAMPLE_W - 2 + CW;      // sum of squares
    localparam int PW  = QW + CW;                    // n*sumsq and sum^2
    localparam int NW2 = 2 * CW;                     // n^2
    localparam int DVW = PW + VAR_FRAC;              // divider dividend

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ    = 4'd1;  // squaring one sample
    localparam logic [3:0] S_START = 4'd2;  // launch the closing pass
    localparam logic [3:0] S_MNQ   = 4'd3;  // n * sumsq
    localparam logic [3:0] S_MSS   = 4'd4;  // sum * sum
    localparam logic [3:0] S_MNN   = 4'd5;  // n * n
    localparam logic [3:0] S_DVM   = 4'd6;  // |sum|*256 / n
    localparam logic [3:0] S_DVV   = 4'd7;  // D*65536 / n^2
    localparam logic [3:0] S_ROOT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    localparam logic [1:0] OP_NQ = 2'd0;
    localparam logic [1:0] OP_SS = 2'd1;
    localparam logic [1:0] OP_NN = 2'd2;

    localparam logic DV_MEAN = 1'b0;
    localparam logic DV_VAR  = 1'b1;

    logic [3:0]                 r_state, n_state;
    logic [CW-1:0]              r_tally;
    logic signed [SW-1:0]       r_sum;
    logic [QW-1:0]              r_sumsq;
    logic                       r_last;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [PW-1:0]              r_p1;
    logic [PW-1:0]              r_dev;
    logic [NW2-1:0]             r_n2;
    logic [OUT_W-1:0]           r_mean;
    logic                       r_out_valid;
    t_msd_out                   r_out_word;

    logic                  in_acc;
    logic                  room;
    logic [SAMPLE_W-1:0]   in_abs;
    logic                  sum_neg;
    logic [SW-1:0]         sum_abs;
    logic [MW-1:0]         mag;
    logic                  out_free;
    logic                  out_load;

    logic                  sq_start, sq_done;
    logic [2*SAMPLE_W-1:0] sq_prod;
    logic                  mul_start, mul_done;
    logic [1:0]            mul_op;
    logic [MW-1:0]         mul_a;
    logic [QW-1:0]         mul_b;
    logic [MW+QW-1:0]      mul_prod;
    logic                  div_start, div_done;
    logic                  div_sel;
    logic [DVW-1:0]        div_n;
    logic [NW2-1:0]        div_d;
    logic [DVW-1:0]        div_q;
    logic [NW2-1:0]        div_r;
    logic                  rt_start, rt_done;
    logic [ROOT_W-1:0]     rt_root;

    logic [OUT_W-1:0]      q_mag, q_up, mean_val;
    logic [CW+COUNT_W-1:0] tally_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign room     = r_tally < CW'(MAX_SAMPLES);
    assign in_abs   = i_in_word.sample[SAMPLE_W-1] ? (~i_in_word.sample + SAMPLE_W'(1))
                                                   : i_in_word.sample;
    assign sum_neg  = r_sum[SW-1];
    assign sum_abs  = sum_neg ? (~r_sum + SW'(1)) : r_sum;
    assign mag      = sum_abs[MW-1:0];
    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == S_OUT) && out_free;

    // sample squarer: 16x16, magnitudes only
    msd_mul #(.AW(SAMPLE_W), .BW(SAMPLE_W)) u_sq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_a     (in_abs),
        .i_b     (in_abs),
        .o_done  (sq_done),
        .o_prod  (sq_prod)
    );

    // shared multiplier of the closing pass; operands picked by mul_op at start
    always_comb begin
        unique case (mul_op)
            OP_NQ: begin
                mul_a = MW'(r_tally);
                mul_b = r_sumsq;
            end
            OP_SS: begin
                mul_a = mag;
                mul_b = QW'(mag);
            end
            default: begin
                mul_a = MW'(r_tally);
                mul_b = QW'(r_tally);
            end
        endcase
    end

    msd_mul #(.AW(MW), .BW(QW)) u_fm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // shared divider: mean magnitude first, then the Q16 variance
    assign div_n = (div_sel == DV_VAR) ? {r_dev, {VAR_FRAC{1'b0}}}
                                       : DVW'({mag, {MEAN_FRAC{1'b0}}});
    assign div_d = (div_sel == DV_VAR) ? r_n2 : NW2'(r_tally);

    msd_div #(.NW(DVW), .DW(NW2)) u_dv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_done     (div_done),
        .o_quot     (div_q),
        .o_rem      (div_r)
    );

    msd_sqrt #(.RW(VAR_W)) u_rt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (rt_start),
        .i_rad   (div_q[VAR_W-1:0]),
        .o_done  (rt_done),
        .o_root  (rt_root)
    );

    // floor of a negative mean: round the magnitude up when the divide left a remainder
    assign q_mag    = div_q[OUT_W-1:0];
    assign q_up     = q_mag + OUT_W'(|div_r);
    assign mean_val = sum_neg ? (~q_up + OUT_W'(1)) : q_mag;

    assign tally_ext = {{COUNT_W{1'b0}}, r_tally};

    // sequencer
    always_comb begin
        n_state   = r_state;
        sq_start  = 1'b0;
        mul_start = 1'b0;
        mul_op    = OP_NQ;
        div_start = 1'b0;
        div_sel   = DV_MEAN;
        rt_start  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (room) begin
                        sq_start = 1'b1;
                        n_state  = S_SQ;
                    end else if (i_in_word.is_last) begin
                        n_state = S_START;
                    end
                end
            end
            S_SQ: begin
                if (sq_done) begin
                    n_state = r_last ? S_START : S_IDLE;
                end
            end
            S_START: begin
                mul_start = 1'b1;
                mul_op    = OP_NQ;
                n_state   = S_MNQ;
            end
            S_MNQ: begin
                mul_op = OP_SS;
                if (mul_done) begin
                    mul_start = 1'b1;
                    n_state   = S_MSS;
                end
            end
            S_MSS: begin
                mul_op = OP_NN;
                if (mul_done) begin
                    mul_start = 1'b1;
                    n_state   = S_MNN;
                end
            end
            S_MNN: begin
                div_sel = DV_MEAN;
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = S_DVM;
                end
            end
            S_DVM: begin
                div_sel = DV_VAR;
                if (div_done) begin
                    div_start = 1'b1;
                    n_state   = S_DVV;
                end
            end
            S_DVV: begin
                div_sel = DV_VAR;
                if (div_done) begin
                    rt_start = 1'b1;
                    n_state  = S_ROOT;
                end
            end
            S_ROOT: begin
                if (rt_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state, running sums and the result register's valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tally     <= '0;
            r_sum       <= '0;
            r_sumsq     <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && in_acc && room) begin
                r_last <= i_in_word.is_last;
            end
            if (r_state == S_SQ && sq_done) begin
                r_sum   <= r_sum + SW'(r_sample);
                r_sumsq <= r_sumsq + QW'(sq_prod);
                r_tally <= r_tally + CW'(1);
            end
            if (out_load) begin
                r_tally     <= '0;
                r_sum       <= '0;
                r_sumsq     <= '0;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath holding registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc) begin
            r_sample <= i_in_word.sample;
        end
        if (r_state == S_MNQ && mul_done) begin
            r_p1 <= mul_prod[PW-1:0];
        end
        if (r_state == S_MSS && mul_done) begin
            r_dev <= r_p1 - mul_prod[PW-1:0];   // n*sumsq - sum^2, never negative
        end
        if (r_state == S_MNN && mul_done) begin
            r_n2 <= mul_prod[NW2-1:0];
        end
        if (r_state == S_DVM && div_done) begin
            r_mean <= mean_val;
        end
        if (out_load) begin
            r_out_word.mean_q8      <= r_mean;
            r_out_word.std_q8       <= OUT_W'(rt_root);
            r_out_word.sample_count <= tally_ext[COUNT_W-1:0];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ===== hw/rtl/msd_chk.sv =====
module msd_chk (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input msd_pkg::t_msd_in  i_in_word,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input msd_pkg::t_msd_out o_out_word
);
    import msd_pkg::*;

    // held result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled result word changed");

    // a word that closes a set always starts the closing pass
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_word.is_last |=> o_in_stall)
        else $error("last word did not start the closing pass");

    // a fresh result only comes out of the closing pass
    a_new_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !($past(o_out_valid) && $past(i_out_stall)) |-> $past(o_in_stall))
        else $error("result appeared while the block was idle");

    // std of 16-bit data stays below 2^23 in Q8
    a_std_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_out_word.std_q8[OUT_W-1])
        else $error("std out of range");

endmodule

bind mean_and_std_deviation msd_chk u_msd_chk (.*);
